@@ rtl/core/dotid_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dotid_pkg
// Shared types, codes and the segment-close function of the dotted
// identifier validator.
// ----------------------------------------------------------------------------
package dotid_pkg;

	localparam int MAX_TOTAL_BYTES_DEF   = 128;
	localparam int MAX_SEGMENT_BYTES_DEF = 32;
	localparam int MAX_SEGMENT_COUNT_DEF = 8;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_DIG_0 = 8'h30;
	localparam logic [7:0] CH_DIG_9 = 8'h39;

	localparam logic [3:0] NS_MIN_SEGMENTS = 4'd2;

	localparam logic [2:0] VERDICT_OK          = 3'd0;
	localparam logic [2:0] VERDICT_EMPTY       = 3'd1;
	localparam logic [2:0] VERDICT_TOO_LONG    = 3'd2;
	localparam logic [2:0] VERDICT_SEG_LONG    = 3'd3;
	localparam logic [2:0] VERDICT_BAD_CHAR    = 3'd4;
	localparam logic [2:0] VERDICT_TOO_MANY    = 3'd5;
	localparam logic [2:0] VERDICT_NO_NAMESPACE = 3'd6;

	typedef struct packed {
		logic [7:0] position;
		logic [7:0] seg_begin;
		logic [3:0] seg_count;
		logic       err_held;
		logic [2:0] held_verdict;
		logic [7:0] held_detail;
		logic       bad_seen;
		logic [7:0] bad_pos;
		logic       first_ok;
	} scan_state_t;

	typedef struct packed {
		logic       emit;
		logic [2:0] verdict;
		logic [7:0] detail;
	} step_res_t;

	function automatic logic [7:0] sat8(input logic [9:0] v);
		return (v > 10'd255) ? 8'd255 : v[7:0];
	endfunction

	function automatic logic lower_alpha(input logic [7:0] c);
		return (c >= CH_LO_A) && (c <= CH_LO_Z);
	endfunction

	function automatic logic body_byte(input logic [7:0] c);
		return lower_alpha(c) || ((c >= CH_DIG_0) && (c <= CH_DIG_9)) || (c == CH_UNDER);
	endfunction

	// Closes the current segment ending just before byte index idx.
	function automatic scan_state_t close_seg(
		input scan_state_t s,
		input logic [8:0]  idx,
		input logic [7:0]  max_seg,
		input logic [3:0]  max_cnt
	);
		scan_state_t r;
		logic [8:0]  len;
		logic [3:0]  cnt;
		r   = s;
		len = (idx >= {1'b0, s.seg_begin}) ? (idx - {1'b0, s.seg_begin}) : 9'd0;
		cnt = s.seg_count + 4'd1;
		if (!s.err_held) begin
			if (len == 9'd0) begin
				r.err_held     = 1'b1;
				r.held_verdict = VERDICT_EMPTY;
				r.held_detail  = s.seg_begin;
			end else if (len > {1'b0, max_seg}) begin
				r.err_held     = 1'b1;
				r.held_verdict = VERDICT_SEG_LONG;
				r.held_detail  = sat8({1'b0, len});
			end else if (!s.first_ok) begin
				r.err_held     = 1'b1;
				r.held_verdict = VERDICT_BAD_CHAR;
				r.held_detail  = s.seg_begin;
			end else if (s.bad_seen) begin
				r.err_held     = 1'b1;
				r.held_verdict = VERDICT_BAD_CHAR;
				r.held_detail  = s.bad_pos;
			end else begin
				r.seg_count = cnt;
				if (cnt > max_cnt) begin
					r.err_held     = 1'b1;
					r.held_verdict = VERDICT_TOO_MANY;
					r.held_detail  = {4'd0, cnt};
				end
			end
		end
		r.seg_begin = sat8({1'b0, idx} + 10'd1);
		r.bad_seen  = 1'b0;
		r.first_ok  = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/dotid_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dotid_step
// Per-byte scan logic: classifies one byte, advances the scan state and
// forms the verdict when the identifier closes.
// ----------------------------------------------------------------------------
module dotid_step #(
	parameter int MAX_TOTAL_BYTES   = dotid_pkg::MAX_TOTAL_BYTES_DEF,
	parameter int MAX_SEGMENT_BYTES = dotid_pkg::MAX_SEGMENT_BYTES_DEF,
	parameter int MAX_SEGMENT_COUNT = dotid_pkg::MAX_SEGMENT_COUNT_DEF
) (
	input  wire dotid_pkg::scan_state_t cur,
	input  wire logic [7:0]             character,
	input  wire logic                   last,
	input  wire logic                   empty_string,
	input  wire logic                   require_namespace,
	output dotid_pkg::scan_state_t      nxt,
	output dotid_pkg::step_res_t        res
);

	localparam logic [7:0] MaxSeg   = 8'(MAX_SEGMENT_BYTES);
	localparam logic [3:0] MaxCnt   = 4'(MAX_SEGMENT_COUNT);
	localparam logic [8:0] MaxTotal = 9'(MAX_TOTAL_BYTES);

	dotid_pkg::scan_state_t mid;
	dotid_pkg::scan_state_t fin;
	logic [8:0]             idx_next;

	always_comb begin
		idx_next = {1'b0, cur.position} + 9'd1;

		mid = cur;
		if (character == dotid_pkg::CH_DOT) begin
			mid = dotid_pkg::close_seg(cur, {1'b0, cur.position}, MaxSeg, MaxCnt);
		end else if (cur.position == cur.seg_begin) begin
			mid.first_ok = dotid_pkg::lower_alpha(character);
		end else if (!dotid_pkg::body_byte(character) && !cur.bad_seen) begin
			mid.bad_seen = 1'b1;
			mid.bad_pos  = cur.position;
		end
		mid.position = dotid_pkg::sat8({1'b0, idx_next});

		// The final segment is closed one past the last byte.
		fin = dotid_pkg::close_seg(mid, idx_next, MaxSeg, MaxCnt);

		res.emit    = 1'b0;
		res.verdict = dotid_pkg::VERDICT_OK;
		res.detail  = 8'd0;
		nxt         = mid;

		if (empty_string) begin
			res.emit    = 1'b1;
			res.verdict = dotid_pkg::VERDICT_EMPTY;
			nxt         = '0;
		end else if (last) begin
			res.emit = 1'b1;
			nxt      = '0;
			if (idx_next > MaxTotal) begin
				res.verdict = dotid_pkg::VERDICT_TOO_LONG;
				res.detail  = dotid_pkg::sat8({1'b0, idx_next});
			end else if (fin.err_held) begin
				res.verdict = fin.held_verdict;
				res.detail  = fin.held_detail;
			end else if (require_namespace && (fin.seg_count < dotid_pkg::NS_MIN_SEGMENTS)) begin
				res.verdict = dotid_pkg::VERDICT_NO_NAMESPACE;
				res.detail  = {4'd0, fin.seg_count};
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/dotid_out_buf.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dotid_out_buf
// Result register holding one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module dotid_out_buf (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire logic [2:0] load_verdict,
	input  wire logic [7:0] load_detail,
	output logic            can_load,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [2:0]      verdict,
	output logic [7:0]      detail
);

	logic       valid_q;
	logic [2:0] verdict_q;
	logic [7:0] detail_q;

	assign can_load     = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign verdict      = verdict_q;
	assign detail       = detail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			verdict_q <= load_verdict;
			detail_q  <= load_detail;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/dotted_identifier_validator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dotted_identifier_validator_core
// Checks a dot-separated identifier streamed one byte per item.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and gives one verdict per
// identifier, on the item marked last or flagged as an empty string. An item
// passes through an input register, where the scan state is advanced by one
// level of classification and compare logic, and its verdict is then loaded
// into the output register. Throughput is one item every cycle; it drops
// only while a finished verdict waits in the output register and the next
// item also closes an identifier.
module dotted_identifier_validator_core #(
	parameter int MAX_TOTAL_BYTES   = dotid_pkg::MAX_TOTAL_BYTES_DEF,
	parameter int MAX_SEGMENT_BYTES = dotid_pkg::MAX_SEGMENT_BYTES_DEF,
	parameter int MAX_SEGMENT_COUNT = dotid_pkg::MAX_SEGMENT_COUNT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire logic [7:0] character,
	input  wire logic       last,
	input  wire logic       empty_string,
	input  wire logic       require_namespace,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [2:0]      verdict,
	output logic [7:0]      detail
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       empty_s1;
	logic       ns_s1;

	dotid_pkg::scan_state_t state_q;
	dotid_pkg::scan_state_t state_nxt;
	dotid_pkg::step_res_t   step_res;

	logic buf_can_load;
	logic advance;

	// The staged item moves on unless its verdict has nowhere to go.
	assign advance    = valid_s1 && (!step_res.emit || buf_can_load);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			char_s1  <= character;
			last_s1  <= last;
			empty_s1 <= empty_string;
			ns_s1    <= require_namespace;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	dotid_step #(
		.MAX_TOTAL_BYTES   (MAX_TOTAL_BYTES),
		.MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES),
		.MAX_SEGMENT_COUNT (MAX_SEGMENT_COUNT)
	) u_step (
		.cur               (state_q),
		.character         (char_s1),
		.last              (last_s1),
		.empty_string      (empty_s1),
		.require_namespace (ns_s1),
		.nxt               (state_nxt),
		.res               (step_res)
	);

	dotid_out_buf u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && step_res.emit),
		.load_verdict (step_res.verdict),
		.load_detail  (step_res.detail),
		.can_load     (buf_can_load),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.verdict      (verdict),
		.detail       (detail)
	);

endmodule
`default_nettype wire

@@ test/dotted_identifier_validator_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotted_identifier_validator_core_test
// Self-checking bench: streams identifiers byte by byte into the validator,
// predicts each verdict with a local scan model and compares verdict and
// detail of every result in order, under random and forced flow control.
// ----------------------------------------------------------------------------
module dotted_identifier_validator_core_test;

	localparam int MAX_TOTAL_BYTES   = dotid_pkg::MAX_TOTAL_BYTES_DEF;
	localparam int MAX_SEGMENT_BYTES = dotid_pkg::MAX_SEGMENT_BYTES_DEF;
	localparam int MAX_SEGMENT_COUNT = dotid_pkg::MAX_SEGMENT_COUNT_DEF;

	typedef struct packed {
		logic [2:0] code;
		logic [7:0] detail;
	} verdict_t;

	typedef enum int {DAMAGE_NOISE, DAMAGE_DOT, DAMAGE_BAD_BODY, DAMAGE_BAD_FIRST} damage_t;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_ready;
	logic [7:0] character;
	logic       last;
	logic       empty_string;
	logic       require_namespace;
	logic       result_valid;
	logic       result_ready;
	logic [2:0] verdict;
	logic [7:0] detail;

	// Scan state of the local model.
	int unsigned scan_pos;
	int unsigned seg_start;
	logic [3:0]  good_segments;
	bit          err_latched;
	logic [2:0]  latched_code;
	logic [7:0]  latched_detail;
	bit          body_bad_seen;
	logic [7:0]  body_bad_pos;
	bit          first_is_letter;

	verdict_t    pending_verdicts[$];
	logic [7:0]  ident_bytes[$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_off_cycles;
	int items_sent;
	int verdicts_checked;
	int mismatch_count;
	int verdict_hits[8];

	dotted_identifier_validator_core #(
		.MAX_TOTAL_BYTES  (MAX_TOTAL_BYTES),
		.MAX_SEGMENT_BYTES(MAX_SEGMENT_BYTES),
		.MAX_SEGMENT_COUNT(MAX_SEGMENT_COUNT)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_ready       (item_ready),
		.character        (character),
		.last             (last),
		.empty_string     (empty_string),
		.require_namespace(require_namespace),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.verdict          (verdict),
		.detail           (detail)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Verdict prediction
	// ------------------------------------------------------------------------
	function automatic int unsigned byte_sat(input int unsigned v);
		return (v > 255) ? 255 : v;
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= dotid_pkg::CH_LO_A) && (c <= dotid_pkg::CH_LO_Z);
	endfunction

	function automatic bit is_body(input logic [7:0] c);
		return is_letter(c) || ((c >= dotid_pkg::CH_DIG_0) && (c <= dotid_pkg::CH_DIG_9))
			|| (c == dotid_pkg::CH_UNDER);
	endfunction

	task automatic queue_verdict(input verdict_t v);
		pending_verdicts.insert(pending_verdicts.size(), v);
	endtask

	task automatic clear_scan();
		scan_pos        = 0;
		seg_start       = 0;
		good_segments   = '0;
		err_latched     = 1'b0;
		latched_code    = dotid_pkg::VERDICT_OK;
		latched_detail  = '0;
		body_bad_seen   = 1'b0;
		body_bad_pos    = '0;
		first_is_letter = 1'b0;
	endtask

	task automatic latch_error(input logic [2:0] code, input int unsigned value);
		err_latched    = 1'b1;
		latched_code   = code;
		latched_detail = 8'(byte_sat(value));
	endtask

	// Closes the segment that ends just before byte index idx; only the first
	// segment error of an identifier is kept.
	task automatic close_segment_at(input int unsigned idx);
		int unsigned seg_len;
		seg_len = (idx >= seg_start) ? idx - seg_start : 0;
		if (!err_latched) begin
			if (seg_len == 0)
				latch_error(dotid_pkg::VERDICT_EMPTY, seg_start);
			else if (seg_len > MAX_SEGMENT_BYTES)
				latch_error(dotid_pkg::VERDICT_SEG_LONG, seg_len);
			else if (!first_is_letter)
				latch_error(dotid_pkg::VERDICT_BAD_CHAR, seg_start);
			else if (body_bad_seen)
				latch_error(dotid_pkg::VERDICT_BAD_CHAR, body_bad_pos);
			else begin
				good_segments = good_segments + 4'd1;
				if (good_segments > MAX_SEGMENT_COUNT)
					latch_error(dotid_pkg::VERDICT_TOO_MANY, good_segments);
			end
		end
		seg_start       = byte_sat(idx + 1);
		body_bad_seen   = 1'b0;
		first_is_letter = 1'b0;
	endtask

	task automatic scan_item(input logic [7:0] ch, input logic lst, input logic emp,
			input logic ns);
		int unsigned idx;
		verdict_t    v;
		if (emp) begin
			clear_scan();
			v.code   = dotid_pkg::VERDICT_EMPTY;
			v.detail = '0;
			queue_verdict(v);
			return;
		end
		idx = scan_pos;
		if (ch == dotid_pkg::CH_DOT)
			close_segment_at(idx);
		else if (idx == seg_start)
			first_is_letter = is_letter(ch);
		else if (!is_body(ch) && !body_bad_seen) begin
			body_bad_seen = 1'b1;
			body_bad_pos  = 8'(byte_sat(idx));
		end
		scan_pos = byte_sat(idx + 1);
		if (!lst)
			return;
		close_segment_at(idx + 1);
		v.code   = dotid_pkg::VERDICT_OK;
		v.detail = '0;
		// Overall length wins over any latched segment error.
		if (idx + 1 > MAX_TOTAL_BYTES) begin
			v.code   = dotid_pkg::VERDICT_TOO_LONG;
			v.detail = 8'(byte_sat(idx + 1));
		end else if (err_latched) begin
			v.code   = latched_code;
			v.detail = latched_detail;
		end else if (ns && good_segments < dotid_pkg::NS_MIN_SEGMENTS) begin
			v.code   = dotid_pkg::VERDICT_NO_NAMESPACE;
			v.detail = {4'd0, good_segments};
		end
		clear_scan();
		queue_verdict(v);
	endtask

	// ------------------------------------------------------------------------
	// Result side: flow control and checking
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles = hold_off_cycles - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && result_valid && result_ready) begin
			verdict_hits[verdict]++;
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("unexpected result verdict %0d detail %0d",
					verdict, detail));
			end else begin
				want = pending_verdicts.pop_front();
				verdicts_checked++;
				if (verdict !== want.code)
					report_mismatch($sformatf("verdict %0d, expected %0d", verdict, want.code));
				if (detail !== want.detail)
					report_mismatch($sformatf("detail %0d, expected %0d (verdict %0d)",
						detail, want.detail, want.code));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Item side
	// ------------------------------------------------------------------------
	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so back-to-back items need no extra edge.
	task automatic send_item(input logic [7:0] ch, input logic lst, input logic emp,
			input logic ns);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid        <= 1'b1;
		character         <= ch;
		last              <= lst;
		empty_string      <= emp;
		require_namespace <= ns;
		do @(posedge clk); while (!item_ready);
		scan_item(ch, lst, emp, ns);
		items_sent++;
		@(negedge clk);
	endtask

	// Sends ident_bytes as one identifier. An empty buffer becomes an empty
	// string item; an abort sends every byte unmarked and then an empty string
	// item that throws them away.
	task automatic send_identifier(input logic ns, input bit abort);
		int n;
		n = ident_bytes.size();
		for (int i = 0; i < n; i++) begin
			send_item(ident_bytes[i], (i == n - 1) && !abort, 1'b0,
				(i == n - 1) ? ns : 1'($urandom_range(1)));
		end
		if (abort || n == 0)
			send_item(8'($urandom_range(255)), (n == 0) ? 1'b1 : 1'($urandom_range(1)),
				1'b1, 1'($urandom_range(1)));
	endtask

	task automatic append_byte(input logic [7:0] b);
		ident_bytes.insert(ident_bytes.size(), b);
	endtask

	task automatic load_text(input string s);
		ident_bytes.delete();
		for (int i = 0; i < s.len(); i++)
			append_byte(s[i]);
	endtask

	function automatic logic [7:0] random_body();
		int r;
		r = $urandom_range(37);
		if (r < 26)
			return dotid_pkg::CH_LO_A + 8'(r);
		if (r < 36)
			return dotid_pkg::CH_DIG_0 + 8'(r - 26);
		return dotid_pkg::CH_UNDER;
	endfunction

	// Appends one well-formed segment of n bytes, preceded by a dot if needed.
	task automatic add_segment(input int n);
		if (ident_bytes.size() != 0)
			append_byte(dotid_pkg::CH_DOT);
		append_byte(dotid_pkg::CH_LO_A + 8'($urandom_range(25)));
		for (int i = 1; i < n; i++)
			append_byte(random_body());
	endtask

	task automatic make_random_identifier();
		int      nseg;
		int      at;
		logic [7:0] c;
		damage_t dmg;
		ident_bytes.delete();
		if ($urandom_range(49) == 0)
			return;
		nseg = ($urandom_range(19) == 0) ? $urandom_range(8, 10) : $urandom_range(1, 4);
		for (int s = 0; s < nseg; s++)
			add_segment(($urandom_range(19) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 6));
		if ($urandom_range(2) != 0)
			return;
		at  = $urandom_range(ident_bytes.size() - 1);
		dmg = damage_t'($urandom_range(3));
		case (dmg)
			DAMAGE_NOISE: begin
				ident_bytes[at] = 8'($urandom_range(255));
			end
			DAMAGE_DOT: begin
				// Lands anywhere, so it also makes leading, trailing and double dots.
				if ($urandom_range(1))
					ident_bytes.insert(at, dotid_pkg::CH_DOT);
				else
					append_byte(dotid_pkg::CH_DOT);
			end
			DAMAGE_BAD_BODY: begin
				do c = 8'($urandom_range(255)); while (is_body(c) || c == dotid_pkg::CH_DOT);
				ident_bytes[at] = c;
			end
			DAMAGE_BAD_FIRST: begin
				ident_bytes[0] = dotid_pkg::CH_DIG_0 + 8'($urandom_range(9));
			end
		endcase
	endtask

	// Stops offering items and waits until every verdict has been checked.
	task automatic finish_phase();
		item_valid <= 1'b0;
		@(negedge clk);
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_directed();
		ident_bytes.delete();
		send_identifier(1'b0, 1'b0);
		// Empty string flag without last drops the bytes already received.
		send_item(dotid_pkg::CH_LO_A, 1'b0, 1'b0, 1'b0);
		send_item(dotid_pkg::CH_LO_A + 8'd1, 1'b0, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1, 1'b0);
		load_text("a");
		send_identifier(1'b1, 1'b0);
		load_text("a.b");
		send_identifier(1'b1, 1'b0);
		load_text("a.");
		send_identifier(1'b0, 1'b0);
		load_text(".a");
		send_identifier(1'b1, 1'b0);
		ident_bytes.delete();
		append_byte(8'h00);
		send_identifier(1'b0, 1'b0);
		ident_bytes.delete();
		append_byte(dotid_pkg::CH_LO_A);
		append_byte(8'hFF);
		send_identifier(1'b0, 1'b0);
		load_text("z_09");
		send_identifier(1'b0, 1'b0);
		load_text("a.9");
		send_identifier(1'b1, 1'b0);
		finish_phase();
	endtask

	task automatic test_length_limits();
		ident_bytes.delete();
		add_segment(MAX_SEGMENT_BYTES);
		send_identifier(1'b0, 1'b0);
		ident_bytes.delete();
		add_segment(MAX_SEGMENT_BYTES + 1);
		send_identifier(1'b0, 1'b0);
		ident_bytes.delete();
		repeat (MAX_SEGMENT_COUNT) add_segment(1);
		send_identifier(1'b1, 1'b0);
		ident_bytes.delete();
		repeat (MAX_SEGMENT_COUNT + 1) add_segment(1);
		send_identifier(1'b1, 1'b0);
		// Exactly at the total limit, then one byte over it.
		ident_bytes.delete();
		repeat (3) add_segment(32);
		add_segment(MAX_TOTAL_BYTES - 99);
		send_identifier(1'b0, 1'b0);
		ident_bytes.delete();
		repeat (3) add_segment(32);
		add_segment(MAX_TOTAL_BYTES - 98);
		send_identifier(1'b0, 1'b0);
		// Well past 255 bytes with a segment error already latched.
		ident_bytes.delete();
		repeat (10) add_segment(29);
		ident_bytes[0] = dotid_pkg::CH_DIG_9;
		send_identifier(1'b1, 1'b0);
		finish_phase();
	endtask

	task automatic test_random(input int byte_budget);
		int start;
		start = items_sent;
		while (items_sent - start < byte_budget) begin
			make_random_identifier();
			send_identifier(1'($urandom_range(1)), ($urandom_range(24) == 0));
		end
		finish_phase();
	endtask

	task automatic test_backpressure();
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		hold_off_cycles = 300;
		repeat (40) begin
			ident_bytes.delete();
			add_segment($urandom_range(1, 2));
			send_identifier(1'($urandom_range(1)), 1'b0);
		end
		finish_phase();
	endtask

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		item_valid        = 1'b0;
		character         = '0;
		last              = 1'b0;
		empty_string      = 1'b0;
		require_namespace = 1'b0;
		result_ready      = 1'b0;
		send_idle_pct     = 19;
		recv_idle_pct     = 70;
		hold_off_cycles   = 0;
		items_sent        = 0;
		verdicts_checked  = 0;
		mismatch_count    = 0;
		clear_scan();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_length_limits();
		test_random(70);
		send_idle_pct = 70;
		recv_idle_pct = 19;
		test_random(70);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(70);
		test_backpressure();

		$display("Sent %0d items and checked %0d verdicts under mixed flow control.",
			items_sent, verdicts_checked);
		$display("Verdicts seen: ok %0d, empty %0d, too long %0d, segment long %0d, %s",
			verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3],
			$sformatf("bad char %0d, too many %0d, no namespace %0d.",
				verdict_hits[4], verdict_hits[5], verdict_hits[6]));
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d verdicts outstanding.", pending_verdicts.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/dotid_pkg.sv
rtl/core/dotid_step.sv
rtl/core/dotid_out_buf.sv
rtl/core/dotted_identifier_validator_core.sv
test/dotted_identifier_validator_core_test.sv
